@@ rtl/spq_pkg.sv @@
// Shared types and constants of the stable priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  // Queue size and stored id width
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Field widths of the channel words
  localparam int ORDER_ID_W = 16;
  localparam int PRIO_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int OCC_W      = 5;

  // Action codes
  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_DEQUEUE = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // One stored queue entry
  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [PRIO_W-1:0]  prio;
  } entry_t;

  // Per-cell control broadcast from the top level
  typedef struct packed {
    logic enq;        // insert the new entry this cycle
    logic deq;        // remove the head this cycle
    logic occ;        // this cell holds a live entry
    logic left_keep;  // left neighbor holds its entry (cell 0: always set)
  } cell_ctl_t;

endpackage

@@ rtl/spq_in_if.sv @@
// Request channel: action, order id and priority.
`timescale 1ns / 1ps

interface spq_in_if;
  logic                            valid;
  logic                            ready;
  logic                            action;
  logic [spq_pkg::ORDER_ID_W-1:0]  order_id;
  logic [spq_pkg::PRIO_W-1:0]      order_priority;

  modport source (output valid, action, order_id, order_priority, input ready);
  modport sink   (input valid, action, order_id, order_priority, output ready);
endinterface

@@ rtl/spq_out_if.sv @@
// Response channel: status, served order and occupancy.
`timescale 1ns / 1ps

interface spq_out_if;
  logic                            valid;
  logic                            ready;
  logic [spq_pkg::STATUS_W-1:0]    status;
  logic [spq_pkg::ORDER_ID_W-1:0]  served_id;
  logic [spq_pkg::PRIO_W-1:0]      served_priority;
  logic [spq_pkg::OCC_W-1:0]       occupancy;

  modport source (output valid, status, served_id, served_priority, occupancy,
                  input ready);
  modport sink   (input valid, status, served_id, served_priority, occupancy,
                  output ready);
endinterface

@@ rtl/spq_cell.sv @@
// One cell of the sorted chain: holds an entry and trades with its neighbors.
`timescale 1ns / 1ps

module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  spq_pkg::entry_t    new_entry,
  input  spq_pkg::entry_t    left_entry,
  input  spq_pkg::entry_t    right_entry,
  output spq_pkg::entry_t    entry,
  output logic               keep
);

  spq_pkg::entry_t entry_next;

  // Hold the entry when it is live and not less urgent than the newcomer
  assign keep = ctl.occ && (entry.prio <= new_entry.prio);

  // Insert: hold, take the newcomer, or shift right; remove: shift left
  always_comb begin
    entry_next = entry;
    if (ctl.enq) begin
      if (keep) begin
        entry_next = entry;
      end else if (ctl.left_keep) begin
        entry_next = new_entry;
      end else begin
        entry_next = left_entry;
      end
    end else if (ctl.deq) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

@@ rtl/stable_priority_queue_core.sv @@
// Top level of the stable sorted priority queue built as a chain of cells.
`timescale 1ns / 1ps
//
// Usage:
//   req carries one word per operation: action 0 enqueues order_id with
//   order_priority (lower is more urgent), action 1 dequeues the head.
//   rsp returns one word per request: status (done, empty, full), the served
//   id and priority on a successful dequeue (zero otherwise) and the number
//   of entries held after the operation.
//   Entries of equal priority leave in arrival order.
// Timing:
//   Each cell of the chain decides locally whether to hold, take the new
//   entry or take a neighbor's entry, so the chain is updated in the cycle
//   of acceptance. The response shows up in the output register in the
//   cycle after acceptance. One request per cycle is taken as long as rsp
//   is drained.
// Reset:
//   rst clears the fill count and the output valid flag; the queue is empty.
// Backpressure:
//   While a response waits in the output register and rsp.ready is low,
//   req.ready is low and the queue state holds.

module stable_priority_queue_core (
  input  logic clk,
  input  logic rst,
  spq_in_if.sink    req,
  spq_out_if.source rsp
);

  localparam int N = spq_pkg::QUEUE_DEPTH;

  logic                       accept;
  logic                       is_full;
  logic                       is_empty;
  logic                       do_enq;
  logic                       do_deq;
  logic [spq_pkg::CNT_W-1:0]  count;
  logic [spq_pkg::CNT_W-1:0]  count_next;
  logic [31:0]                id_wide;
  logic [31:0]                head_id_wide;
  logic [31:0]                count_wide;
  spq_pkg::entry_t            new_entry;
  spq_pkg::entry_t            entries [N];
  logic                       keeps   [N];

  logic                                rsp_valid;
  logic [spq_pkg::STATUS_W-1:0]        status;
  logic [spq_pkg::STATUS_W-1:0]        status_next;
  logic [spq_pkg::ORDER_ID_W-1:0]      served_id;
  logic [spq_pkg::ORDER_ID_W-1:0]      served_id_next;
  logic [spq_pkg::PRIO_W-1:0]          served_priority;
  logic [spq_pkg::PRIO_W-1:0]          served_priority_next;
  logic [spq_pkg::OCC_W-1:0]           occupancy;
  logic [spq_pkg::OCC_W-1:0]           occupancy_next;

  // Accept when the output register is free or being drained
  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign is_full  = (count == spq_pkg::CNT_W'(N));
  assign is_empty = (count == '0);
  assign do_enq   = accept && (req.action == spq_pkg::ACT_ENQUEUE) && !is_full;
  assign do_deq   = accept && (req.action == spq_pkg::ACT_DEQUEUE) && !is_empty;

  // Fit the incoming id to the stored width
  assign id_wide         = 32'(req.order_id);
  assign new_entry.id    = id_wide[spq_pkg::ID_BITS-1:0];
  assign new_entry.prio  = req.order_priority;

  // Chain of cells, head at index 0
  for (genvar i = 0; i < N; i++) begin : g_cell
    spq_pkg::cell_ctl_t ctl;
    spq_pkg::entry_t    left_entry;
    spq_pkg::entry_t    right_entry;

    assign ctl.enq = do_enq;
    assign ctl.deq = do_deq;
    assign ctl.occ = (spq_pkg::CNT_W'(i) < count);

    if (i == 0) begin : g_head
      assign ctl.left_keep = 1'b1;
      assign left_entry    = new_entry;
    end else begin : g_body
      assign ctl.left_keep = keeps[i-1];
      assign left_entry    = entries[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .new_entry   (new_entry),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entries[i]),
      .keep        (keeps[i])
    );
  end

  // Advance the fill count
  always_comb begin
    count_next = count;
    if (do_enq) begin
      count_next = count + 1'b1;
    end else if (do_deq) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Build the response word
  assign head_id_wide = 32'(entries[0].id);
  assign count_wide   = 32'(count_next);

  always_comb begin
    status_next          = spq_pkg::ST_DONE;
    served_id_next       = '0;
    served_priority_next = '0;
    occupancy_next       = count_wide[spq_pkg::OCC_W-1:0];
    if (req.action == spq_pkg::ACT_ENQUEUE) begin
      if (is_full) begin
        status_next = spq_pkg::ST_FULL;
      end
    end else if (is_empty) begin
      status_next = spq_pkg::ST_EMPTY;
    end else begin
      served_id_next       = head_id_wide[spq_pkg::ORDER_ID_W-1:0];
      served_priority_next = entries[0].prio;
    end
  end

  // Output register: valid is control, the word is payload
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status          <= status_next;
      served_id       <= served_id_next;
      served_priority <= served_priority_next;
      occupancy       <= occupancy_next;
    end
  end

  assign rsp.valid           = rsp_valid;
  assign rsp.status          = status;
  assign rsp.served_id       = served_id;
  assign rsp.served_priority = served_priority;
  assign rsp.occupancy       = occupancy;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= spq_pkg::CNT_W'(N))
    else $error("fill count exceeds queue depth");

  a_deq_shrinks: assert property (@(posedge clk) disable iff (rst)
    do_deq |=> count == $past(count) - 1'b1)
    else $error("dequeue did not shrink the queue");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (accept && req.action == spq_pkg::ACT_ENQUEUE && is_full)
      |=> rsp.status == spq_pkg::ST_FULL)
    else $error("enqueue on full queue not reported");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |-> !req.ready)
    else $error("request taken while response stalled");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (count >= spq_pkg::CNT_W'(2)) |-> entries[0].prio <= entries[1].prio)
    else $error("head entry out of order");

endmodule

@@ tb/stable_priority_queue_core_tb.sv @@
// Testbench of the stable priority queue core: predicted responses checked word by word.
`timescale 1ns / 1ps

module stable_priority_queue_core_tb;

  localparam int STALL_LIMIT = 3000;  // cycles with no word moved before giving up
  localparam int HOLD_LEN    = 80;    // long receiver hold-off, in cycles

  typedef struct {
    logic [spq_pkg::STATUS_W-1:0]   status;
    logic [spq_pkg::ORDER_ID_W-1:0] id;
    logic [spq_pkg::PRIO_W-1:0]     prio;
    logic [spq_pkg::OCC_W-1:0]      occ;
  } response_t;

  logic clk;
  logic rst;

  spq_in_if  req_ch ();
  spq_out_if rsp_ch ();

  stable_priority_queue_core DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  // Shadow copy of the sorted queue, head at index 0
  spq_pkg::entry_t shadow_q[$];
  response_t       pending_responses[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_seq       = 0;  // bumped by a test to request a long hold-off
  int error_count    = 0;
  int idle_cycles    = 0;
  int n_words_sent   = 0;
  int n_enqueues     = 0;
  int n_dequeues     = 0;
  int n_full_hits    = 0;
  int n_empty_hits   = 0;
  int n_checked      = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Compute the response of one request and advance the shadow queue
  function automatic response_t predict_response(logic act,
                                                 logic [spq_pkg::ORDER_ID_W-1:0] id,
                                                 logic [spq_pkg::PRIO_W-1:0] prio);
    response_t       r;
    spq_pkg::entry_t e;
    int              pos;
    r.status = spq_pkg::ST_DONE;
    r.id     = '0;
    r.prio   = '0;
    if (act == spq_pkg::ACT_ENQUEUE) begin
      if (shadow_q.size() >= spq_pkg::QUEUE_DEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        // land after every entry of equal or more urgent priority
        pos = 0;
        while (pos < shadow_q.size() && shadow_q[pos].prio <= prio) pos++;
        e.id   = spq_pkg::ID_BITS'(id);
        e.prio = prio;
        shadow_q.insert(pos, e);
      end
    end else begin
      if (shadow_q.size() == 0) begin
        r.status = spq_pkg::ST_EMPTY;
      end else begin
        e      = shadow_q.pop_front();
        r.id   = spq_pkg::ORDER_ID_W'(e.id);
        r.prio = e.prio;
      end
    end
    r.occ = spq_pkg::OCC_W'(shadow_q.size());
    return r;
  endfunction

  // Offer one request word, hold it until taken, then record its response
  task automatic send_word(logic act, logic [spq_pkg::ORDER_ID_W-1:0] id,
                           logic [spq_pkg::PRIO_W-1:0] prio);
    response_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.action         <= act;
    req_ch.order_id       <= id;
    req_ch.order_priority <= prio;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    r = predict_response(act, id, prio);
    pending_responses.push_back(r);
    n_words_sent++;
    if (act == spq_pkg::ACT_ENQUEUE) n_enqueues++;
    else n_dequeues++;
    if (r.status == spq_pkg::ST_FULL) n_full_hits++;
    if (r.status == spq_pkg::ST_EMPTY) n_empty_hits++;
  endtask

  // Drop valid and wait until every response is back
  task automatic wait_for_responses();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_responses.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_queue();
    send_word(spq_pkg::ACT_DEQUEUE, 16'h0000, 3'd0);
    send_word(spq_pkg::ACT_DEQUEUE, 16'hFFFF, 3'd7);
  endtask

  // Fill with extreme ids and tied priorities, overflow once, drain a few
  task automatic test_fill_and_overflow();
    logic [spq_pkg::ORDER_ID_W-1:0] id;
    logic [spq_pkg::PRIO_W-1:0]     prio;
    for (int i = 0; i < spq_pkg::QUEUE_DEPTH; i++) begin
      id   = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF :
             spq_pkg::ORDER_ID_W'(i * 16'h1111 ^ 16'h00A5);
      prio = (i % 4 == 0) ? 3'd7 : (i % 4 == 1) ? 3'd0 : 3'd3;
      send_word(spq_pkg::ACT_ENQUEUE, id, prio);
    end
    send_word(spq_pkg::ACT_ENQUEUE, 16'hBEEF, 3'd0);
    send_word(spq_pkg::ACT_DEQUEUE, 16'hFFFF, 3'd7);
    send_word(spq_pkg::ACT_DEQUEUE, 16'h0000, 3'd0);
    send_word(spq_pkg::ACT_DEQUEUE, 16'h5A5A, 3'd5);
  endtask

  // Random traffic in segments that lean toward filling or draining
  task automatic test_random_traffic(int n, int send_pct, int recv_pct);
    int   enq_bias;
    logic act;
    logic [spq_pkg::PRIO_W-1:0] prio;
    logic [spq_pkg::PRIO_W-1:0] tie_a;
    logic [spq_pkg::PRIO_W-1:0] tie_b;
    wait_for_responses();
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    enq_bias = 50;
    tie_a    = 3'd1;
    tie_b    = 3'd5;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: enq_bias = 80;
          1: enq_bias = 20;
          default: enq_bias = 55;
        endcase
        tie_a = spq_pkg::PRIO_W'($urandom_range(0, 7));
        tie_b = spq_pkg::PRIO_W'($urandom_range(0, 7));
      end
      act = ($urandom_range(0, 99) < enq_bias) ? spq_pkg::ACT_ENQUEUE : spq_pkg::ACT_DEQUEUE;
      // crowd on two priorities now and then to stress tie ordering
      if ($urandom_range(0, 2) == 0) prio = $urandom_range(0, 1) ? tie_a : tie_b;
      else prio = spq_pkg::PRIO_W'($urandom_range(0, 7));
      send_word(act, spq_pkg::ORDER_ID_W'($urandom), prio);
    end
  endtask

  // Hold the receiver off long enough that the block stalls its input
  task automatic test_output_backpressure();
    wait_for_responses();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_seq++;
    for (int i = 0; i < 40; i++) begin
      send_word(($urandom_range(0, 99) < 70) ? spq_pkg::ACT_ENQUEUE : spq_pkg::ACT_DEQUEUE,
                spq_pkg::ORDER_ID_W'($urandom), spq_pkg::PRIO_W'($urandom_range(0, 7)));
    end
  endtask

  // Pause the sender until everything is back, then resume
  task automatic test_drain_then_resume();
    recv_stall_pct = 20;
    send_idle_pct  = 0;
    for (int k = 0; k < 3; k++) begin
      wait_for_responses();
      for (int i = 0; i < 20; i++) begin
        send_word(($urandom_range(0, 1) == 0) ? spq_pkg::ACT_ENQUEUE : spq_pkg::ACT_DEQUEUE,
                  spq_pkg::ORDER_ID_W'($urandom), spq_pkg::PRIO_W'($urandom_range(0, 7)));
      end
    end
  endtask

  // Receiver: random stalls, or a long hold-off when a test asks for one
  initial begin
    int seen_seq;
    int hold_left;
    seen_seq  = 0;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != seen_seq) begin
        seen_seq  = hold_seq;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: mismatch on %s: expected %0d, got %0d", $time, name, exp_val, act_val);
      error_count++;
    end
  endtask

  // Check each response word against the oldest prediction; watch for a hang
  always @(posedge clk) begin
    response_t exp_r;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_responses.size() == 0) begin
          $display("%0t: response word with nothing expected: status %0d id %0h prio %0d occ %0d",
                   $time, rsp_ch.status, rsp_ch.served_id, rsp_ch.served_priority,
                   rsp_ch.occupancy);
          error_count++;
        end else begin
          exp_r = pending_responses.pop_front();
          check_field("status", exp_r.status, rsp_ch.status);
          check_field("served_id", exp_r.id, rsp_ch.served_id);
          check_field("served_priority", exp_r.prio, rsp_ch.served_priority);
          check_field("occupancy", exp_r.occ, rsp_ch.occupancy);
          n_checked++;
        end
      end
      if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no word moved for %0d cycles, %0d responses outstanding",
                 $time, STALL_LIMIT, pending_responses.size());
        $display("stable_priority_queue_core_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst                   = 1'b1;
    req_ch.valid          <= 1'b0;
    req_ch.action         <= spq_pkg::ACT_ENQUEUE;
    req_ch.order_id       <= '0;
    req_ch.order_priority <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_queue();
    test_fill_and_overflow();
    test_output_backpressure();
    test_random_traffic(300, 0, 0);
    test_random_traffic(300, 85, 0);
    test_random_traffic(300, 0, 85);
    test_random_traffic(300, 20, 20);
    test_drain_then_resume();

    // let the last response land, then check that none is outstanding
    wait_for_responses();
    repeat (5) @(posedge clk);
    if (pending_responses.size() != 0) begin
      $display("%0t: %0d responses never arrived", $time, pending_responses.size());
      error_count++;
    end

    $display("Covered %0d requests (%0d enqueues, %0d dequeues) with %0d full rejects and",
             n_words_sent, n_enqueues, n_dequeues, n_full_hits);
    $display("%0d empty dequeues; %0d responses checked, %0d errors, under four idle mixes",
             n_empty_hits, n_checked, error_count);
    if (error_count == 0) begin
      $display("stable_priority_queue_core_tb: PASS");
    end else begin
      $display("stable_priority_queue_core_tb: FAIL");
    end
    $finish;
  end

endmodule
